[sv/fsnd_pkg.sv]
// fsnd_pkg: shared constants and types of the frame stability detector
// no dependencies
`default_nettype none

package fsnd_pkg;

  localparam int SCORE_W = 16;           // signed q2.14 score
  localparam int LO_W    = 15;           // score magnitude 0..16384
  localparam int D_W     = 15;           // 2*m-1 for a trial magnitude m
  localparam int D2_W    = 30;           // (2*m-1)^2
  localparam int FRAC_SH = 30;           // 4 * 16384^2 = 2^30
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LO_W-1:0] ONE_Q14 = LO_W'(16384);

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd16056;
  localparam logic [7:0]  NEEDED_RST    = 8'd3;
  localparam logic [15:0] LIMIT_RST     = 16'd30;

  typedef struct packed {
    logic                      done;
    logic signed [SCORE_W-1:0] score;
  } ncc_res_t;

endpackage

`default_nettype wire

[sv/fsnd_if.sv]
// fsnd_if: valid/ready channels of the frame stability detector
// depends on nothing; pixel request channel and result channel
`default_nettype none

interface fsnd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] pixel;
  logic [7:0] frame_width;
  logic [7:0] frame_height;
  logic       last_pixel;

  modport source (output valid, action, pixel, frame_width, frame_height, last_pixel,
                  input ready);
  modport sink   (input valid, action, pixel, frame_width, frame_height, last_pixel,
                  output ready);
endinterface

interface fsnd_out_if;
  logic               valid;
  logic               ready;
  logic               stable;
  logic               timed_out;
  logic signed [15:0] score;
  logic [15:0]        stable_run;
  logic [15:0]        frames_checked;
  logic               compared;

  modport source (output valid, stable, timed_out, score, stable_run, frames_checked,
                  compared, input ready);
  modport sink   (input valid, stable, timed_out, score, stable_run, frames_checked,
                  compared, output ready);
endinterface

`default_nettype wire

[sv/frame_stability_ncc_detector.sv]
// frame_stability_ncc_detector: top level, pixel accumulation, frame decisions
// depends on fsnd_pkg, fsnd_if, fsnd_frame_mem and fsnd_ncc
//
// px_i takes grey pixels in raster order (action 0) or a clear request (action 1).
// Each pixel reads the stored previous frame at its place through a registered read, adds to
// the one-pass sums and overwrites the entry; pixels flow one per cycle while px_i.ready is high.
// The last pixel of a frame produces one result on res_o; clears produce none.
// The result is presented in ST_OUT, reached through ST_EVAL for a first frame or a
// timeout and through ST_EVAL and ST_DEC for a size mismatch; a compared frame
// runs the sequential scorer, whose shared shift-add multiplier computes 6 products
// for a flat frame and 8 plus 2 per search trial (1 or 15 trials) otherwise.
// px_i.ready stays low from the last pixel until the result is taken, so a stalled
// receiver holds the result and back-pressures the pixel source.
// Reset clears all detector state and loads the register defaults; the frame store
// holds no meaningful data until the first frame is written.
// cfg_we_i writes register cfg_idx_i (0 threshold, 1 run length, 2 frame limit).
`default_nettype none

module frame_stability_ncc_detector #(
  parameter int MAX_DIM = 128
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [fsnd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [fsnd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  fsnd_in_if.sink                                px_i,
  fsnd_out_if.source                             res_o
);

  localparam int PIX_CAP = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(PIX_CAP);
  localparam int CNT_W   = $clog2(PIX_CAP + 1);
  localparam int SUM_W   = CNT_W + 8;
  localparam int SQ_W    = CNT_W + 16;
  localparam int CMP_W   = (CNT_W > 16) ? CNT_W : 16;

  typedef enum logic [2:0] {ST_PIX, ST_EVAL, ST_NCC, ST_DEC, ST_OUT} state_e;

  state_e             st_q;
  logic signed [15:0] thr_q;
  logic [7:0]         need_q;
  logic [15:0]        limit_q;
  logic               has_prev_q;
  logic [7:0]         prev_w_q, prev_h_q;
  logic [7:0]         cur_w_q, cur_h_q;
  logic [15:0]        fc_q, run_q;
  logic               stable_q, to_q, cmp_q;
  logic signed [15:0] score_q, sc_q;
  logic               ncc_go_q;

  logic               s1_vld_q, s1_last_q, s1_inr_q;
  logic [7:0]         s1_pix_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic [CNT_W-1:0]   idx_q;
  logic               ovf_q;
  logic [SUM_W-1:0]   s1_sum_q, s2_sum_q;
  logic [SQ_W-1:0]    q1_q, q2_q, p_q;

  logic               acc, px_acc, clr_acc, in_rng;
  logic [7:0]         prev_pix;
  logic               malformed, timeout, frame_end, score_ok;
  logic [15:0]        fc_n, run_n, area;
  fsnd_pkg::ncc_res_t ncc_res;

  assign px_i.ready = (st_q == ST_PIX) && !(s1_vld_q && s1_last_q);
  assign acc        = px_i.valid && px_i.ready;
  assign px_acc     = acc && !px_i.action;
  assign clr_acc    = acc && px_i.action;
  assign in_rng     = (idx_q < CNT_W'(PIX_CAP));

  assign area      = 16'(cur_w_q) * 16'(cur_h_q);
  assign malformed = ovf_q || (CMP_W'(idx_q) != CMP_W'(area));
  assign fc_n      = (fc_q == 16'hFFFF) ? fc_q : fc_q + 16'd1;
  assign timeout   = to_q || (fc_n > limit_q);
  assign run_n     = (run_q == 16'hFFFF) ? run_q : run_q + 16'd1;
  assign score_ok  = (sc_q >= thr_q);
  // the frame is finished once its result is settled
  assign frame_end = (st_q == ST_DEC) || ((st_q == ST_EVAL) && (timeout || !has_prev_q));

  fsnd_frame_mem #(.DEPTH(PIX_CAP), .ADDR_W(ADDR_W)) u_mem (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q && s1_inr_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pix_q),
    .re_i    (px_acc && in_rng),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (prev_pix)
  );

  fsnd_ncc #(.CNT_W(CNT_W)) u_ncc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ncc_go_q),
    .n_i     (idx_q),
    .s1_i    (s1_sum_q),
    .s2_i    (s2_sum_q),
    .q1_i    (q1_q),
    .q2_i    (q2_q),
    .p_i     (p_q),
    .res_o   (ncc_res)
  );

  // pixel stage, counters and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s1_inr_q  <= 1'b0;
      s1_pix_q  <= '0;
      s1_addr_q <= '0;
      idx_q     <= '0;
      ovf_q     <= 1'b0;
      s1_sum_q  <= '0;
      s2_sum_q  <= '0;
      q1_q      <= '0;
      q2_q      <= '0;
      p_q       <= '0;
    end else begin
      s1_vld_q <= px_acc;
      if (px_acc) begin
        s1_last_q <= px_i.last_pixel;
        s1_inr_q  <= in_rng;
        s1_pix_q  <= px_i.pixel;
        s1_addr_q <= idx_q[ADDR_W-1:0];
        if (in_rng) idx_q <= idx_q + CNT_W'(1);
        else        ovf_q <= 1'b1;
      end
      if (clr_acc || frame_end) begin
        idx_q    <= '0;
        ovf_q    <= 1'b0;
        s1_sum_q <= '0;
        s2_sum_q <= '0;
        q1_q     <= '0;
        q2_q     <= '0;
        p_q      <= '0;
      end else if (s1_vld_q && s1_inr_q) begin
        s1_sum_q <= s1_sum_q + SUM_W'(s1_pix_q);
        s2_sum_q <= s2_sum_q + SUM_W'(prev_pix);
        q1_q     <= q1_q + SQ_W'(16'(s1_pix_q) * 16'(s1_pix_q));
        q2_q     <= q2_q + SQ_W'(16'(prev_pix) * 16'(prev_pix));
        p_q      <= p_q + SQ_W'(16'(s1_pix_q) * 16'(prev_pix));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_PIX;
      thr_q      <= $signed(fsnd_pkg::THRESHOLD_RST);
      need_q     <= fsnd_pkg::NEEDED_RST;
      limit_q    <= fsnd_pkg::LIMIT_RST;
      has_prev_q <= 1'b0;
      prev_w_q   <= '0;
      prev_h_q   <= '0;
      cur_w_q    <= '0;
      cur_h_q    <= '0;
      fc_q       <= '0;
      run_q      <= '0;
      stable_q   <= 1'b0;
      to_q       <= 1'b0;
      cmp_q      <= 1'b0;
      score_q    <= '0;
      sc_q       <= '0;
      ncc_go_q   <= 1'b0;
    end else begin
      ncc_go_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fsnd_pkg::CFG_THRESHOLD: thr_q   <= $signed(cfg_data_i);
          fsnd_pkg::CFG_NEEDED:    need_q  <= cfg_data_i[7:0];
          fsnd_pkg::CFG_LIMIT:     limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (st_q)
        ST_PIX: begin
          if (clr_acc) begin
            has_prev_q <= 1'b0;
            prev_w_q   <= '0;
            prev_h_q   <= '0;
            fc_q       <= '0;
            run_q      <= '0;
            stable_q   <= 1'b0;
            to_q       <= 1'b0;
            score_q    <= '0;
          end
          if (px_acc && px_i.last_pixel) begin
            cur_w_q <= px_i.frame_width;
            cur_h_q <= px_i.frame_height;
          end
          if (s1_vld_q && s1_last_q) st_q <= ST_EVAL;
        end
        ST_EVAL: begin
          fc_q     <= fc_n;
          cmp_q    <= 1'b0;
          prev_w_q <= malformed ? 8'd0 : cur_w_q;
          prev_h_q <= malformed ? 8'd0 : cur_h_q;
          if (timeout) begin
            to_q     <= 1'b1;
            stable_q <= 1'b0;
            st_q     <= ST_OUT;
          end else if (!has_prev_q) begin
            has_prev_q <= 1'b1;
            st_q       <= ST_OUT;
          end else if (malformed || cur_w_q != prev_w_q || cur_h_q != prev_h_q) begin
            sc_q <= '0;
            st_q <= ST_DEC;
          end else begin
            ncc_go_q <= 1'b1;
            st_q     <= ST_NCC;
          end
        end
        ST_NCC: begin
          if (ncc_res.done) begin
            sc_q <= ncc_res.score;
            st_q <= ST_DEC;
          end
        end
        ST_DEC: begin
          score_q <= sc_q;
          cmp_q   <= 1'b1;
          if (score_ok) begin
            run_q <= run_n;
            if (run_n >= 16'(need_q)) stable_q <= 1'b1;
          end else begin
            run_q    <= '0;
            stable_q <= 1'b0;
          end
          st_q <= ST_OUT;
        end
        ST_OUT: if (res_o.ready) st_q <= ST_PIX;
        default: st_q <= ST_PIX;
      endcase
    end
  end

  assign res_o.valid          = (st_q == ST_OUT);
  assign res_o.stable         = stable_q;
  assign res_o.timed_out      = to_q;
  assign res_o.score          = score_q;
  assign res_o.stable_run     = run_q;
  assign res_o.frames_checked = fc_q;
  assign res_o.compared       = cmp_q;

endmodule

`default_nettype wire

[sv/fsnd_frame_mem.sv]
// fsnd_frame_mem: previous frame store, one write and one registered read port
// no dependencies
`default_nettype none

module fsnd_frame_mem #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/fsnd_mul.sv]
// fsnd_mul: shift-add multiplier, one multiplier bit per cycle
// no dependencies; product kept modulo 2^P_W
`default_nettype none

module fsnd_mul #(
  parameter int A_W = 90,
  parameter int B_W = 45,
  parameter int P_W = 120
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [A_W-1:0] a_i,
  input  wire logic [B_W-1:0] b_i,
  output logic      [P_W-1:0] p_o,
  output logic                done_o
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_q;
  logic [B_W-1:0]   b_q;
  logic [P_W-1:0]   acc_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [P_W-1:0]   addend;

  assign addend = b_q[B_W-1] ? P_W'(a_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[P_W-2:0], 1'b0} + addend;
      b_q   <= {b_q[B_W-2:0], 1'b0};
    end
  end

  assign p_o    = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[sv/fsnd_ncc.sv]
// fsnd_ncc: end-of-frame correlation score sequencer around one shared multiplier
// depends on fsnd_pkg and fsnd_mul
`default_nettype none

module fsnd_ncc #(
  parameter int CNT_W = 15
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [CNT_W-1:0]           n_i,
  input  wire logic [CNT_W+7:0]           s1_i,
  input  wire logic [CNT_W+7:0]           s2_i,
  input  wire logic [CNT_W+15:0]          q1_i,
  input  wire logic [CNT_W+15:0]          q2_i,
  input  wire logic [CNT_W+15:0]          p_i,
  output fsnd_pkg::ncc_res_t              res_o
);

  localparam int V_W = 2 * CNT_W + 16;
  localparam int A_W = 2 * V_W;
  localparam int B_W = V_W;
  localparam int P_W = 2 * V_W + fsnd_pkg::FRAC_SH;
  localparam int K_W = $clog2(fsnd_pkg::LO_W);

  typedef enum logic [3:0] {
    S_IDLE, S_NQ1, S_SQ1, S_NQ2, S_SQ2, S_NP, S_SP, S_VV, S_CC,
    S_DSQ, S_DV, S_CMP, S_DONE
  } state_e;

  state_e                    state_q;
  logic                      start_q;
  logic [V_W-1:0]            t0_q, v1_q, v2_q, cmag_q;
  logic                      neg_q;
  logic [A_W-1:0]            vv_q;
  logic [P_W-1:0]            r_q, lhs_q;
  logic [fsnd_pkg::D2_W-1:0] d2_q;
  logic [fsnd_pkg::LO_W-1:0] lo_q, m_q;
  logic [K_W-1:0]            k_q;
  logic                      first_q;

  logic [A_W-1:0]            mul_a;
  logic [B_W-1:0]            mul_b;
  logic [P_W-1:0]            mul_p;
  logic                      mul_done;
  logic [fsnd_pkg::D_W-1:0]  d;
  logic [V_W:0]              diff;
  logic [V_W:0]              diff_neg;
  logic [V_W-1:0]            v_new;
  logic                      ok;
  logic [fsnd_pkg::LO_W-1:0] lo_n;

  assign d        = fsnd_pkg::D_W'({m_q, 1'b0} - {(fsnd_pkg::LO_W)'(0), 1'b1});
  assign diff     = {1'b0, t0_q} - {1'b0, mul_p[V_W-1:0]};
  assign diff_neg = '0 - diff;
  assign v_new    = t0_q - mul_p[V_W-1:0];
  assign ok       = (lhs_q <= r_q);
  assign lo_n     = ok ? m_q : lo_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_NQ1: begin mul_a = A_W'(q1_i);   mul_b = B_W'(n_i);    end
      S_SQ1: begin mul_a = A_W'(s1_i);   mul_b = B_W'(s1_i);   end
      S_NQ2: begin mul_a = A_W'(q2_i);   mul_b = B_W'(n_i);    end
      S_SQ2: begin mul_a = A_W'(s2_i);   mul_b = B_W'(s2_i);   end
      S_NP:  begin mul_a = A_W'(p_i);    mul_b = B_W'(n_i);    end
      S_SP:  begin mul_a = A_W'(s1_i);   mul_b = B_W'(s2_i);   end
      S_VV:  begin mul_a = A_W'(v1_q);   mul_b = v2_q;         end
      S_CC:  begin mul_a = A_W'(cmag_q); mul_b = cmag_q;       end
      S_DSQ: begin mul_a = A_W'(d);      mul_b = B_W'(d);      end
      S_DV:  begin mul_a = vv_q;         mul_b = B_W'(d2_q);   end
      default: ;
    endcase
  end

  fsnd_mul #(.A_W(A_W), .B_W(B_W), .P_W(P_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .p_o     (mul_p),
    .done_o  (mul_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
      first_q <= 1'b0;
      k_q     <= '0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) begin state_q <= S_NQ1; start_q <= 1'b1; end
        S_NQ1:  if (mul_done) begin state_q <= S_SQ1; start_q <= 1'b1; end
        S_SQ1:  if (mul_done) begin state_q <= S_NQ2; start_q <= 1'b1; end
        S_NQ2:  if (mul_done) begin state_q <= S_SQ2; start_q <= 1'b1; end
        S_SQ2:  if (mul_done) begin state_q <= S_NP;  start_q <= 1'b1; end
        S_NP:   if (mul_done) begin state_q <= S_SP;  start_q <= 1'b1; end
        S_SP: begin
          if (mul_done) begin
            // zero variance in either frame scores a full 1.0
            if (v1_q == '0 || v2_q == '0) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_VV;
              start_q <= 1'b1;
            end
          end
        end
        S_VV:   if (mul_done) begin state_q <= S_CC; start_q <= 1'b1; end
        S_CC: begin
          if (mul_done) begin
            state_q <= S_DSQ;
            start_q <= 1'b1;
            first_q <= 1'b1;
          end
        end
        S_DSQ:  if (mul_done) begin state_q <= S_DV; start_q <= 1'b1; end
        S_DV:   if (mul_done) state_q <= S_CMP;
        S_CMP: begin
          if (first_q) begin
            first_q <= 1'b0;
            k_q     <= K_W'(fsnd_pkg::LO_W - 2);
            if (ok) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_DSQ;
              start_q <= 1'b1;
            end
          end else if (k_q == '0) begin
            state_q <= S_DONE;
          end else begin
            k_q     <= k_q - K_W'(1);
            state_q <= S_DSQ;
            start_q <= 1'b1;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_NQ1, S_NQ2, S_NP: if (mul_done) t0_q <= mul_p[V_W-1:0];
      S_SQ1: if (mul_done) v1_q <= v_new;
      S_SQ2: if (mul_done) v2_q <= v_new;
      S_SP: begin
        if (mul_done) begin
          if (v1_q == '0 || v2_q == '0) begin
            neg_q <= 1'b0;
            lo_q  <= fsnd_pkg::ONE_Q14;
          end else begin
            neg_q  <= diff[V_W];
            cmag_q <= diff[V_W] ? diff_neg[V_W-1:0] : diff[V_W-1:0];
          end
        end
      end
      S_VV: if (mul_done) vv_q <= mul_p[A_W-1:0];
      S_CC: begin
        if (mul_done) begin
          r_q  <= mul_p << fsnd_pkg::FRAC_SH;
          lo_q <= '0;
          m_q  <= fsnd_pkg::ONE_Q14;
        end
      end
      S_DSQ: if (mul_done) d2_q <= mul_p[fsnd_pkg::D2_W-1:0];
      S_DV:  if (mul_done) lhs_q <= mul_p;
      S_CMP: begin
        // bitwise search for the largest magnitude whose lower half-step still fits
        if (first_q) begin
          if (ok) lo_q <= fsnd_pkg::ONE_Q14;
          m_q <= fsnd_pkg::LO_W'(1) << (fsnd_pkg::LO_W - 2);
        end else begin
          lo_q <= lo_n;
          if (k_q != '0) m_q <= lo_n | (fsnd_pkg::LO_W'(1) << (k_q - K_W'(1)));
        end
      end
      default: ;
    endcase
  end

  assign res_o.done  = (state_q == S_DONE);
  assign res_o.score = neg_q ? -$signed(fsnd_pkg::SCORE_W'(lo_q))
                             : $signed(fsnd_pkg::SCORE_W'(lo_q));

endmodule

`default_nettype wire
